// File: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and character constants for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t [MAX_RES-1:0] res;
  } push_t;

endpackage

// File: rtl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Escape state and the single-pass decode of one byte into up to three results.
// ----------------------------------------------------------------------------
module upd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          issue,
  input  logic [7:0]    data,
  input  logic          last,
  input  logic          plus_as_space,
  output upd_pkg::push_t push
);
  import upd_pkg::*;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] first_digit;
  logic [3:0] first_digit_next;
  logic       digit_lower;
  logic       digit_lower_next;
  logic       stopped;
  logic       stopped_next;

  res_t       res_w [0:3];
  logic [1:0] n;
  logic       ended;
  logic       do_plain;
  logic       is_hex;
  logic       is_lower;
  logic [3:0] hex_v;
  logic       is_ws;

  function automatic logic [7:0] digit_byte(logic [3:0] d, logic lo);
    logic [7:0] base;
    if (d < 4'd10) begin
      return 8'h30 + {4'd0, d};
    end
    base = lo ? 8'h61 : 8'h41;
    return base + {4'd0, d} - 8'd10;
  endfunction

  always_comb begin
    is_hex   = 1'b0;
    is_lower = 1'b0;
    hex_v    = 4'd0;
    if (data >= 8'h30 && data <= 8'h39) begin
      is_hex = 1'b1;
      hex_v  = data[3:0];
    end else if (data >= 8'h41 && data <= 8'h46) begin
      is_hex = 1'b1;
      hex_v  = 4'(data - 8'h41 + 8'd10);
    end else if (data >= 8'h61 && data <= 8'h66) begin
      is_hex   = 1'b1;
      is_lower = 1'b1;
      hex_v    = 4'(data - 8'h61 + 8'd10);
    end
    is_ws = (data == CH_SPACE) || (data >= CH_TAB && data <= CH_CR);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res_w[i] = '0;
    end
    n                = 2'd0;
    ended            = 1'b0;
    do_plain         = 1'b0;
    phase_next       = phase;
    first_digit_next = first_digit;
    digit_lower_next = digit_lower;
    stopped_next     = stopped;

    if (stopped) begin
      if (last) begin
        stopped_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_PCT: begin
          if (is_hex) begin
            first_digit_next = hex_v;
            digit_lower_next = is_lower;
            phase_next       = PH_DIGIT;
          end else begin
            phase_next = PH_NONE;
            res_w[n]   = '{data: CH_PERCENT, valid: 1'b1, last: 1'b0};
            n          = 2'(n + 2'd1);
            do_plain   = 1'b1;
          end
        end
        PH_DIGIT: begin
          phase_next = PH_NONE;
          if (is_hex && ({first_digit, hex_v} != 8'd0)) begin
            res_w[n] = '{data: {first_digit, hex_v}, valid: 1'b1, last: 1'b0};
            n        = 2'(n + 2'd1);
          end else begin
            res_w[n] = '{data: CH_PERCENT, valid: 1'b1, last: 1'b0};
            n        = 2'(n + 2'd1);
            res_w[n] = '{data: digit_byte(first_digit, digit_lower), valid: 1'b1,
                         last: 1'b0};
            n        = 2'(n + 2'd1);
            do_plain = 1'b1;
          end
        end
        default: begin
          phase_next = PH_NONE;
          do_plain   = 1'b1;
        end
      endcase

      if (do_plain) begin
        if (is_ws) begin
          stopped_next = 1'b1;
          ended        = 1'b1;
        end else if (data == CH_PERCENT) begin
          phase_next = PH_PCT;
        end else begin
          res_w[n] = '{data: (plus_as_space && data == CH_PLUS) ? CH_SPACE : data,
                       valid: 1'b1, last: 1'b0};
          n        = 2'(n + 2'd1);
        end
      end

      if (last && !ended) begin
        if (phase_next == PH_PCT) begin
          res_w[n] = '{data: CH_PERCENT, valid: 1'b1, last: 1'b0};
          n        = 2'(n + 2'd1);
        end else if (phase_next == PH_DIGIT) begin
          res_w[n] = '{data: CH_PERCENT, valid: 1'b1, last: 1'b0};
          n        = 2'(n + 2'd1);
          res_w[n] = '{data: digit_byte(first_digit_next, digit_lower_next),
                       valid: 1'b1, last: 1'b0};
          n        = 2'(n + 2'd1);
        end
        ended = 1'b1;
      end

      if (ended) begin
        phase_next = PH_NONE;
        if (n != 2'd0) begin
          res_w[2'(n - 2'd1)].last = 1'b1;
        end else begin
          res_w[0] = '{data: 8'd0, valid: 1'b0, last: 1'b1};
          n        = 2'd1;
        end
      end

      if (last) begin
        stopped_next = 1'b0;
        phase_next   = PH_NONE;
      end
    end
  end

  always_comb begin
    push.count = issue ? n : 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      push.res[i] = res_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NONE;
      first_digit <= 4'd0;
      digit_lower <= 1'b0;
      stopped     <= 1'b0;
    end else if (issue) begin
      phase       <= phase_next;
      first_digit <= first_digit_next;
      digit_lower <= digit_lower_next;
      stopped     <= stopped_next;
    end
  end

endmodule

// File: rtl/upd_res_queue.sv
// ----------------------------------------------------------------------------
// upd_res_queue
// Four-entry result queue that takes up to three results a cycle and hands
// one beat a cycle to the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module upd_res_queue (
  input  logic           clk,
  input  logic           rst,
  input  upd_pkg::push_t push,
  output logic           space_ok,
  output logic           result_valid,
  input  logic           result_stall,
  output upd_pkg::res_t  head
);
  import upd_pkg::*;

  res_t       mem [0:3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign result_valid = (count != 3'd0);
  assign pop          = result_valid && !result_stall;
  assign space_ok     = (count <= 3'd1) || (count == 3'd2 && pop);
  assign count_next   = count + {1'b0, push.count} - {2'd0, pop};
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.count) begin
        mem[2'(wr_ptr + 2'(i))] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= 2'(wr_ptr + push.count);
      rd_ptr <= 2'(rd_ptr + {1'b0, pop});
      count  <= count_next;
    end
  end

endmodule

// File: rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Decodes a URI byte stream, turning %XX escapes into bytes.
// ----------------------------------------------------------------------------
// Input beats (in_byte, in_last) enter on in_valid and are held back by
// in_stall. Result beats (out_byte, out_valid, out_last) leave on
// result_valid and are held by result_stall; out_valid low marks a bare
// end-of-token marker. The plus_as_space register is written with cfg_write
// and cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. An accepted byte is registered, decoded
// in one pass and written into a four-entry result queue, whose head drives
// the outputs. The block takes one byte per cycle while the result queue
// has space. A byte that yields two or three results can hold the input
// back, because the result queue drains a single beat per cycle when the
// receiver does not stall.
// Reset empties the queue, clears the escape state and sets plus_as_space.
// While the receiver stalls, the head result holds and the queue fills; the
// input is stalled once the queue cannot take another three results.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);
  import upd_pkg::*;

  logic       plus_as_space;
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;
  logic       space_ok;
  logic       issue;
  push_t      push;
  res_t       head;

  assign issue    = s_valid && space_ok;
  assign in_stall = s_valid && !issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b1;
    end else if (cfg_write) begin
      plus_as_space <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_byte <= in_byte;
      s_last <= in_last;
    end
  end

  upd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .issue         (issue),
    .data          (s_byte),
    .last          (s_last),
    .plus_as_space (plus_as_space),
    .push          (push)
  );

  upd_res_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .space_ok     (space_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign out_byte  = head.data;
  assign out_valid = head.valid;
  assign out_last  = head.last;

endmodule

// File: rtl/upd_checker.sv
// ----------------------------------------------------------------------------
// upd_port_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !result_valid && !in_stall)
    else $error("block not empty after reset");

  a_marker_form : assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> out_last && out_byte == 8'd0)
    else $error("bare marker without last flag or with data");

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(out_byte) && $stable(out_valid) && $stable(out_last))
    else $error("result beat changed while stalled");

endmodule

bind url_percent_decoder upd_port_checker u_upd_port_checker (.*);

// File: test/upd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_checker
// Watches the decoder's channels, predicts every result beat and compares.
// Each accepted input beat is decoded by an independent model of the escape
// state machine, and the beats it yields are queued. Each accepted result
// beat is checked field by field against the oldest queued beat. The number
// of failures and of beats still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module upd_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] out_byte,
  input  logic       out_valid,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  import upd_pkg::*;

  localparam logic [7:0] DIG_0   = 8'h30;
  localparam logic [7:0] DIG_9   = 8'h39;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_F = 8'h46;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_F = 8'h66;
  localparam logic [4:0] NOT_HEX = 5'd16;

  res_t       decoded_beats[$];
  res_t       head;
  int         step_count;
  logic       token_done;
  logic       plus_as_space;
  logic [1:0] esc_phase;
  logic [3:0] held_digit;
  logic       held_lower;
  logic       skipping;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = {3'd0, NOT_HEX};
    if (b >= DIG_0 && b <= DIG_9) begin
      d = b - DIG_0;
    end else if (b >= UPPER_A && b <= UPPER_F) begin
      d = b - UPPER_A + 8'd10;
    end else if (b >= LOWER_A && b <= LOWER_F) begin
      d = b - LOWER_A + 8'd10;
    end
    return d[4:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    if (d < 4'd10) begin
      return DIG_0 + {4'b0, d};
    end
    return (lower ? LOWER_A : UPPER_A) + {4'b0, d} - 8'd10;
  endfunction

  function void emit_byte(input logic [7:0] v);
    res_t r;
    r.data  = v;
    r.valid = 1'b1;
    r.last  = 1'b0;
    decoded_beats.push_back(r);
    step_count++;
  endfunction

  function void take_plain(input logic [7:0] b);
    if (is_space(b)) begin
      skipping   = 1'b1;
      token_done = 1'b1;
    end else if (b == CH_PERCENT) begin
      esc_phase = PH_PCT;
    end else if (b == CH_PLUS && plus_as_space) begin
      emit_byte(CH_SPACE);
    end else begin
      emit_byte(b);
    end
  endfunction

  function void decode_byte(input logic [7:0] b, input logic lst);
    logic [4:0] v;
    logic [7:0] pair;
    res_t       r;
    step_count = 0;
    token_done = 1'b0;
    if (skipping) begin
      if (lst) begin
        skipping = 1'b0;
      end
    end else begin
      v = hex_value(b);
      case (esc_phase)
        PH_PCT: begin
          if (v != NOT_HEX) begin
            held_digit = v[3:0];
            held_lower = (b >= LOWER_A && b <= LOWER_F);
            esc_phase  = PH_DIGIT;
          end else begin
            esc_phase = PH_NONE;
            emit_byte(CH_PERCENT);
            take_plain(b);
          end
        end
        PH_DIGIT: begin
          pair      = (v != NOT_HEX) ? {held_digit, v[3:0]} : 8'd0;
          esc_phase = PH_NONE;
          if (pair != 8'd0) begin
            emit_byte(pair);
          end else begin
            emit_byte(CH_PERCENT);
            emit_byte(digit_char(held_digit, held_lower));
            take_plain(b);
          end
        end
        default: begin
          esc_phase = PH_NONE;
          take_plain(b);
        end
      endcase
      if (lst && !token_done) begin
        if (esc_phase == PH_PCT) begin
          emit_byte(CH_PERCENT);
        end else if (esc_phase == PH_DIGIT) begin
          emit_byte(CH_PERCENT);
          emit_byte(digit_char(held_digit, held_lower));
        end
        token_done = 1'b1;
      end
      if (token_done) begin
        esc_phase = PH_NONE;
        if (step_count > 0) begin
          r = decoded_beats.pop_back();
          r.last = 1'b1;
          decoded_beats.push_back(r);
        end else begin
          r.data  = 8'd0;
          r.valid = 1'b0;
          r.last  = 1'b1;
          decoded_beats.push_back(r);
        end
      end
      if (lst) begin
        skipping  = 1'b0;
        esc_phase = PH_NONE;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      plus_as_space = 1'b1;
      esc_phase     = PH_NONE;
      held_digit    = 4'd0;
      held_lower    = 1'b0;
      skipping      = 1'b0;
      fail_count    = 0;
      decoded_beats.delete();
    end else begin
      if (cfg_write) begin
        plus_as_space = cfg_data;
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, in_last);
      end
      if (result_valid && !result_stall) begin
        if (decoded_beats.size() == 0) begin
          $error("result beat with nothing expected: out_byte %02h, out_valid %0b, out_last %0b",
                 out_byte, out_valid, out_last);
          fail_count++;
        end else begin
          head = decoded_beats.pop_front();
          if (out_byte !== head.data) begin
            $error("out_byte: expected %02h, got %02h", head.data, out_byte);
            fail_count++;
          end
          if (out_valid !== head.valid) begin
            $error("out_valid: expected %0b, got %0b", head.valid, out_valid);
            fail_count++;
          end
          if (out_last !== head.last) begin
            $error("out_last: expected %0b, got %0b", head.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending <= decoded_beats.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the URL percent decoder.
// A directed sequence covers good and bad escapes, both letter cases, the
// plus mapping, whitespace ends and trailing bytes. Random tokens follow in
// three phases with different idling on both channels and different values
// of the plus mapping. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb;
  import upd_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         FINAL_CYCLES   = 20;
  localparam int         PHASE_ITEMS    = 60;
  localparam logic [7:0] DIG_0          = 8'h30;
  localparam logic [7:0] UPPER_A        = 8'h41;
  localparam logic [7:0] LOWER_A        = 8'h61;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_write    = 1'b0;
  logic       cfg_data     = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_byte      = 8'd0;
  logic       in_last      = 1'b0;
  logic       result_stall = 1'b0;
  logic       in_stall;
  logic       result_valid;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  int         fail_count;
  int         pending;
  int         items_sent    = 0;
  int         quiet_cycles  = 0;
  int         send_idle_pct = 7;
  int         recv_idle_pct = 79;
  logic [7:0] token_bytes[$];

  url_percent_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last)
  );

  upd_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("url_percent_decoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // The first edge lets the checker's count catch up with the last beat sent.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_plus(input logic v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] rand_hex();
    logic [7:0] v;
    v = 8'($urandom_range(21));
    if (v < 8'd10) begin
      return DIG_0 + v;
    end else if (v < 8'd16) begin
      return UPPER_A + v - 8'd10;
    end
    return LOWER_A + v - 8'd16;
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] v;
    v = 8'($urandom_range(5));
    return (v == 8'd5) ? CH_SPACE : CH_TAB + v;
  endfunction

  task automatic send_token();
    int   pieces;
    logic noisy;
    logic lst;
    pieces = $urandom_range(1, 6);
    noisy  = ($urandom_range(7) == 0);
    token_bytes.delete();
    repeat (pieces) begin
      if (noisy) begin
        token_bytes.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0, 1: token_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
          2: token_bytes.push_back(CH_PLUS);
          3, 4: begin
            token_bytes.push_back(CH_PERCENT);
            token_bytes.push_back(rand_hex());
            token_bytes.push_back(rand_hex());
          end
          5: begin
            token_bytes.push_back(CH_PERCENT);
            token_bytes.push_back(8'($urandom_range(255)));
          end
          6: begin
            token_bytes.push_back(CH_PERCENT);
            token_bytes.push_back(rand_hex());
            token_bytes.push_back(8'($urandom_range(255)));
          end
          7: token_bytes.push_back(rand_space());
          8: token_bytes.push_back(8'($urandom_range(255)));
          default: token_bytes.push_back(CH_PERCENT);
        endcase
      end
    end
    foreach (token_bytes[i]) begin
      lst = (i == token_bytes.size() - 1);
      if (noisy) begin
        lst = ($urandom_range(3) == 0);
      end
      send_beat(token_bytes[i], lst);
    end
  endtask

  task automatic run_phase(input int target);
    while (items_sent < target - PHASE_ITEMS / 2) send_token();
    drain();
    while (items_sent < target) send_token();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_beat(CH_PERCENT, 1'b0);
    send_beat("4", 1'b0);
    send_beat("1", 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("2", 1'b0);
    send_beat("b", 1'b0);
    send_beat(CH_PLUS, 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("0", 1'b0);
    send_beat("0", 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("a", 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("g", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("f", 1'b0);
    send_beat(CH_SPACE, 1'b0);
    send_beat("q", 1'b0);
    send_beat(8'h7F, 1'b1);
    send_beat(CH_PERCENT, 1'b1);
    send_beat(CH_CR, 1'b1);
    send_beat("z", 1'b1);

    write_plus(1'b0);
    send_beat(CH_PLUS, 1'b0);
    send_beat(CH_PERCENT, 1'b0);
    send_beat("2", 1'b0);
    send_beat("B", 1'b1);

    write_plus(1'b1);
    run_phase(items_sent + PHASE_ITEMS);

    send_idle_pct = 79;
    recv_idle_pct = 7;
    write_plus(1'b0);
    run_phase(items_sent + PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_plus(1'b1);
    run_phase(items_sent + PHASE_ITEMS);

    drain();
    repeat (FINAL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("url_percent_decoder test passed");
    end else begin
      $display("url_percent_decoder test failed");
    end
    $finish;
  end

endmodule
